FILE: design/rlst_pkg.sv
// ----------------------------------------------------------------------------
// rlst_pkg
// Shared constants, codes and types of the reference-counted label slot table.
// ----------------------------------------------------------------------------
`default_nettype none

package rlst_pkg;

   // default geometry
   localparam int NUM_MAPS_DEF      = 64;
   localparam int SLOTS_PER_MAP_DEF = 16;
   localparam int LABEL_BITS_DEF    = 16;

   // fixed field widths of the request and response ports
   localparam int OPCODE_W    = 2;
   localparam int MAP_INDEX_W = 6;
   localparam int REQ_LABEL_W = 16;
   localparam int STATUS_W    = 2;
   localparam int SLOT_OUT_W  = 4;
   localparam int COUNT_W     = 16;

   localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

   // request opcodes
   localparam logic [OPCODE_W-1:0] OP_ACQUIRE = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_RELEASE = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_CLEAR   = 2'd2;

   // response status codes
   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NO_SPACE  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;

   // outcome of one row update
   typedef struct packed {
      logic                  write_en;
      logic [STATUS_W-1:0]   status;
      logic [SLOT_OUT_W-1:0] slot;
      logic [COUNT_W-1:0]    ref_count;
   } rlst_result_type;

endpackage : rlst_pkg

`default_nettype wire

FILE: design/rlst_row_update.sv
// ----------------------------------------------------------------------------
// rlst_row_update
// Compares all slots of one bank row, applies acquire or release and builds
// the row to write back together with the response fields.
// ----------------------------------------------------------------------------
`default_nettype none

module rlst_row_update import rlst_pkg::*; #(
   parameter int SLOTS_PER_MAP = SLOTS_PER_MAP_DEF,
   parameter int LABEL_BITS    = LABEL_BITS_DEF
) (
   input  wire logic [OPCODE_W-1:0]                             opcode,
   input  wire logic                                            in_range,
   input  wire logic                                            row_valid,
   input  wire logic [LABEL_BITS-1:0]                           label,
   input  wire logic [SLOTS_PER_MAP-1:0][LABEL_BITS+COUNT_W:0]  row_in,
   output logic      [SLOTS_PER_MAP-1:0][LABEL_BITS+COUNT_W:0]  row_out,
   output rlst_result_type                                      result
);

   localparam int SLOT_W = $clog2(SLOTS_PER_MAP);
   localparam int OCC_B  = LABEL_BITS + COUNT_W;

   logic [SLOTS_PER_MAP-1:0][LABEL_BITS+COUNT_W:0] row_m;
   logic [SLOTS_PER_MAP-1:0] hit_vec;
   logic [SLOTS_PER_MAP-1:0] free_vec;
   logic [SLOT_W-1:0]        hit_idx;
   logic [SLOT_W-1:0]        free_idx;
   logic [COUNT_W-1:0]       hit_cnt;
   logic [COUNT_W-1:0]       new_cnt;

   // mask occupancy of a row that has not been written since reset or clear
   always_comb begin
      for (int s = 0; s < SLOTS_PER_MAP; s++) begin
         row_m[s]        = row_in[s];
         row_m[s][OCC_B] = row_in[s][OCC_B] & row_valid;
         hit_vec[s]      = row_m[s][OCC_B] && (row_m[s][COUNT_W +: LABEL_BITS] == label);
         free_vec[s]     = !row_m[s][OCC_B];
      end
   end

   // lowest matching and lowest free slot
   always_comb begin
      hit_idx  = '0;
      free_idx = '0;
      for (int s = SLOTS_PER_MAP - 1; s >= 0; s--) begin
         if (hit_vec[s]) begin
            hit_idx = SLOT_W'(s);
         end
         if (free_vec[s]) begin
            free_idx = SLOT_W'(s);
         end
      end
   end

   assign hit_cnt = row_m[hit_idx][COUNT_W-1:0];

   always_comb begin
      row_out = row_m;
      result  = '{write_en: 1'b0, status: ST_OK, slot: '0, ref_count: '0};
      new_cnt = '0;
      unique case (opcode)
         OP_ACQUIRE: begin
            if (!in_range) begin
               result.status = ST_NO_SPACE;
            end else if (|hit_vec) begin
               new_cnt                       = (hit_cnt == COUNT_MAX) ? hit_cnt
                                                                      : hit_cnt + 16'd1;
               row_out[hit_idx][COUNT_W-1:0] = new_cnt;
               result.write_en               = 1'b1;
               result.slot                   = SLOT_OUT_W'(hit_idx);
               result.ref_count              = new_cnt;
            end else if (|free_vec) begin
               new_cnt           = 16'd1;
               row_out[free_idx] = {1'b1, label, new_cnt};
               result.write_en   = 1'b1;
               result.slot       = SLOT_OUT_W'(free_idx);
               result.ref_count  = new_cnt;
            end else begin
               result.status = ST_NO_SPACE;
            end
         end
         OP_RELEASE: begin
            if (!in_range || !(|hit_vec)) begin
               result.status = ST_NOT_FOUND;
            end else begin
               // drop the slot when its count falls below one
               if (hit_cnt <= 16'd1) begin
                  row_out[hit_idx] = '0;
               end else begin
                  new_cnt                       = hit_cnt - 16'd1;
                  row_out[hit_idx][COUNT_W-1:0] = new_cnt;
               end
               result.write_en  = 1'b1;
               result.slot      = SLOT_OUT_W'(hit_idx);
               result.ref_count = new_cnt;
            end
         end
         default: begin
            // clear and the unused code answer ok with zero fields
         end
      endcase
   end

endmodule : rlst_row_update

`default_nettype wire

FILE: design/refcounted_label_slot_table.sv
// ----------------------------------------------------------------------------
// refcounted_label_slot_table
// Banked table of labels with reference counts: acquire, release and clear.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low, the addressed
// bank row is read from the row memory on that edge, and in the following
// cycle (busy high) the row is compared slot by slot, modified and written
// back. The response fields are registered at the end of the work cycle and
// shown in the cycle after it as a single-cycle pulse on rsp_valid; the
// receiver cannot stall it, and a new request may be issued in the same cycle
// the response is shown. No request is taken while busy is high, so the read
// and the write-back of the row memory never coincide. Reset and the clear
// opcode empty the table at once through one valid flag per bank row; no
// clearing pass is needed. Labels are the low LABEL_BITS bits of req_label.
// ----------------------------------------------------------------------------
`default_nettype none

module refcounted_label_slot_table import rlst_pkg::*; #(
   parameter int NUM_MAPS      = NUM_MAPS_DEF,
   parameter int SLOTS_PER_MAP = SLOTS_PER_MAP_DEF,
   parameter int LABEL_BITS    = LABEL_BITS_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   // request channel
   input  wire logic                   start,
   output logic                        busy,
   input  wire logic [OPCODE_W-1:0]    req_opcode,
   input  wire logic [MAP_INDEX_W-1:0] req_map_index,
   input  wire logic [REQ_LABEL_W-1:0] req_label,
   // response channel
   output logic                        rsp_valid,
   output logic [STATUS_W-1:0]         rsp_status,
   output logic [SLOT_OUT_W-1:0]       rsp_slot,
   output logic [COUNT_W-1:0]          rsp_ref_count
);

   localparam int ROW_AW  = (NUM_MAPS > 1) ? $clog2(NUM_MAPS) : 1;
   localparam int ENTRY_W = 1 + LABEL_BITS + COUNT_W;
   localparam int LIMIT_W = 9;   // holds NUM_MAPS up to 511

   // sequencer codes
   localparam logic S_IDLE = 1'b0;
   localparam logic S_WORK = 1'b1;

   logic state_ff, state_in;
   logic accept;

   // request captured at acceptance
   logic [OPCODE_W-1:0]   op_ff;
   logic [LABEL_BITS-1:0] label_ff;
   logic [ROW_AW-1:0]     addr_ff;
   logic                  in_range_ff;
   logic [ROW_AW-1:0]     req_addr;
   logic                  req_in_range;

   // row memory and per-row valid flags
   logic [SLOTS_PER_MAP-1:0][ENTRY_W-1:0] row_mem [NUM_MAPS];
   logic [SLOTS_PER_MAP-1:0][ENTRY_W-1:0] rd_row_ff;
   logic [SLOTS_PER_MAP-1:0][ENTRY_W-1:0] wr_row;
   logic [NUM_MAPS-1:0]                   row_vld_ff;
   logic                                  rd_vld_ff;
   logic                                  mem_wr;

   rlst_result_type upd_result;

   // response registers
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]   rsp_status_ff;
   logic [SLOT_OUT_W-1:0] rsp_slot_ff;
   logic [COUNT_W-1:0]    rsp_ref_count_ff;

   assign busy         = (state_ff == S_WORK);
   assign accept       = start && !busy;
   assign req_addr     = ROW_AW'(req_map_index);
   assign req_in_range = LIMIT_W'(req_map_index) < LIMIT_W'(NUM_MAPS);

   // advance: idle -> work on acceptance, work always returns to idle
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:  state_in = accept ? S_WORK : S_IDLE;
         S_WORK:  state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   assign rsp_valid_in = busy;
   assign mem_wr       = busy && upd_result.write_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         row_vld_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         // clear empties every bank at once; a write-back marks its row live
         if (busy && (op_ff == OP_CLEAR)) begin
            row_vld_ff <= '0;
         end else if (mem_wr) begin
            row_vld_ff[addr_ff] <= 1'b1;
         end
      end
   end

   // hold the request for the work cycle
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff       <= req_opcode;
         label_ff    <= LABEL_BITS'(req_label);
         addr_ff     <= req_addr;
         in_range_ff <= req_in_range;
         rd_vld_ff   <= row_vld_ff[req_addr];
      end
   end

   // row memory: read on acceptance, write back at the end of the work cycle;
   // the two never coincide, so no forwarding is needed
   always_ff @(posedge clock) begin
      if (accept) begin
         rd_row_ff <= row_mem[req_addr];
      end
      if (mem_wr) begin
         row_mem[addr_ff] <= wr_row;
      end
   end

   rlst_row_update #(
      .SLOTS_PER_MAP (SLOTS_PER_MAP),
      .LABEL_BITS    (LABEL_BITS)
   ) u_row_update (
      .opcode    (op_ff),
      .in_range  (in_range_ff),
      .row_valid (rd_vld_ff),
      .label     (label_ff),
      .row_in    (rd_row_ff),
      .row_out   (wr_row),
      .result    (upd_result)
   );

   // register the response fields of the finished transaction
   always_ff @(posedge clock) begin
      if (busy) begin
         rsp_status_ff    <= upd_result.status;
         rsp_slot_ff      <= upd_result.slot;
         rsp_ref_count_ff <= upd_result.ref_count;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_slot      = rsp_slot_ff;
   assign rsp_ref_count = rsp_ref_count_ff;

`ifndef SYNTHESIS
   // every response follows exactly one work cycle
   a_rsp_after_work: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("response without a preceding work cycle");

   // the work phase lasts a single cycle
   a_work_one_cycle: assert property (@(posedge clock) disable iff (reset)
      busy |=> !busy)
      else $error("busy held beyond one cycle");

   // an accepted request always enters the work phase
   a_accept_to_work: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted request did not start work");

   // a failed request reports zero slot and zero count
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != ST_OK)) |-> ((rsp_slot == '0) && (rsp_ref_count == '0)))
      else $error("failed request with non-zero fields");

   // a successful acquire never reports a count of zero
   a_acquire_nonzero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && $past(op_ff == OP_ACQUIRE) && (rsp_status == ST_OK)) |->
         (rsp_ref_count != '0))
      else $error("acquire returned zero count");
`endif

endmodule : refcounted_label_slot_table

`default_nettype wire
